// ----- rtl/hbd_pkg.sv -----
// Shared constants, types and state codes for the Huffman tree decoder.
`timescale 1ns / 1ps

package hbd_pkg;

  // Alphabet size and derived tree geometry
  localparam int SYMBOL_COUNT = 8;
  localparam int NODE_TOTAL   = 2 * SYMBOL_COUNT - 1;
  localparam int ROOT_NODE    = 2 * SYMBOL_COUNT - 2;
  localparam int INT_COUNT    = SYMBOL_COUNT - 1;
  localparam int SYM_IDX_W    = $clog2(SYMBOL_COUNT);
  localparam int NODE_W       = $clog2(NODE_TOTAL);
  localparam int INT_W        = (INT_COUNT > 1) ? $clog2(INT_COUNT) : 1;

  // Field widths
  localparam int WEIGHT_W    = 16;
  localparam int SUM_W       = WEIGHT_W + SYM_IDX_W;
  localparam int SYM_W       = 3;
  localparam int CFG_INDEX_W = SYM_IDX_W + 1;

  // Weights after reset, symbol 0 in the lowest slot; unlisted symbols get 1
  localparam logic [15:0][WEIGHT_W-1:0] RESET_WEIGHTS = {
    16'd1, 16'd1, 16'd1, 16'd1, 16'd1, 16'd1, 16'd1, 16'd1,
    16'd10, 16'd21, 16'd3, 16'd32, 16'd6, 16'd2, 16'd19, 16'd7
  };

  typedef logic [NODE_W-1:0] node_t;
  typedef logic [SUM_W-1:0]  sum_t;

  // Built tree as seen by the decoder: child 0 and child 1 of each internal node
  typedef struct packed {
    logic                                  valid;
    logic [INT_COUNT-1:0][1:0][NODE_W-1:0] child;
  } tree_t;

  // Tree builder sequencer
  typedef enum logic [1:0] {
    BLD_LOAD,
    BLD_SCAN,
    BLD_MERGE,
    BLD_DONE
  } bld_state_t;

endpackage

// ----- rtl/hbd_tree_builder.sv -----
// Weight registers and the sequential Huffman tree builder.
`timescale 1ns / 1ps

module hbd_tree_builder (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [hbd_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [hbd_pkg::WEIGHT_W-1:0]    cfg_data,
  output hbd_pkg::tree_t                  tree
);

  logic [hbd_pkg::WEIGHT_W-1:0] weight [hbd_pkg::SYMBOL_COUNT];
  hbd_pkg::sum_t                node_weight [hbd_pkg::NODE_TOTAL];
  logic [hbd_pkg::NODE_TOTAL-1:0] active;
  logic [hbd_pkg::INT_COUNT-1:0][1:0][hbd_pkg::NODE_W-1:0] child;

  hbd_pkg::bld_state_t state, state_next;
  hbd_pkg::node_t      next_node;
  hbd_pkg::node_t      scan;
  hbd_pkg::node_t      lo, hi;
  logic                lo_ok, hi_ok;
  hbd_pkg::sum_t       wlo, whi;
  logic                tree_valid;

  logic                             cfg_hit;
  logic [hbd_pkg::SYM_IDX_W-1:0]    cfg_sym;
  logic                             weight_change;
  logic                             scan_last;
  logic                             last_merge;
  hbd_pkg::sum_t                    wm;
  hbd_pkg::node_t                   row_full;
  logic [hbd_pkg::INT_W-1:0]        row;

  assign cfg_ready = 1'b1;

  // Register write decode; only a real change of weight forces a rebuild
  assign cfg_sym       = cfg_index[hbd_pkg::SYM_IDX_W-1:0];
  assign cfg_hit       = cfg_valid &&
                         (cfg_index < hbd_pkg::CFG_INDEX_W'(hbd_pkg::SYMBOL_COUNT));
  assign weight_change = cfg_hit && (weight[cfg_sym] != cfg_data);

  assign wm         = node_weight[scan];
  assign scan_last  = (scan == hbd_pkg::node_t'(next_node - 1'b1));
  assign last_merge = (next_node == hbd_pkg::node_t'(hbd_pkg::ROOT_NODE));
  assign row_full   = hbd_pkg::node_t'(next_node - hbd_pkg::node_t'(hbd_pkg::SYMBOL_COUNT));
  assign row        = row_full[hbd_pkg::INT_W-1:0];

  // Weight registers
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < hbd_pkg::SYMBOL_COUNT; k++) begin
        weight[k] <= hbd_pkg::RESET_WEIGHTS[k % 16];
      end
    end else if (weight_change) begin
      weight[cfg_sym] <= cfg_data;
    end
  end

  // Sequencer state
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= hbd_pkg::BLD_LOAD;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      hbd_pkg::BLD_LOAD:  state_next = hbd_pkg::BLD_SCAN;
      hbd_pkg::BLD_SCAN:  if (scan_last) state_next = hbd_pkg::BLD_MERGE;
      hbd_pkg::BLD_MERGE: state_next = last_merge ? hbd_pkg::BLD_DONE : hbd_pkg::BLD_SCAN;
      hbd_pkg::BLD_DONE:  state_next = hbd_pkg::BLD_DONE;
      default:            state_next = hbd_pkg::BLD_LOAD;
    endcase
    if (weight_change) state_next = hbd_pkg::BLD_LOAD;
  end

  // Tree ready flag
  always_ff @(posedge clk) begin
    if (rst) begin
      tree_valid <= 1'b0;
    end else if (weight_change) begin
      tree_valid <= 1'b0;
    end else if (state == hbd_pkg::BLD_MERGE && last_merge) begin
      tree_valid <= 1'b1;
    end
  end

  // Build datapath: load leaves, scan one node a cycle for the two lowest, merge
  always_ff @(posedge clk) begin
    case (state)
      hbd_pkg::BLD_LOAD: begin
        for (int n = 0; n < hbd_pkg::NODE_TOTAL; n++) begin
          active[n] <= (n < hbd_pkg::SYMBOL_COUNT);
        end
        for (int n = 0; n < hbd_pkg::SYMBOL_COUNT; n++) begin
          node_weight[n] <= hbd_pkg::sum_t'(weight[n]);
        end
        next_node <= hbd_pkg::node_t'(hbd_pkg::SYMBOL_COUNT);
        scan      <= '0;
        lo_ok     <= 1'b0;
        hi_ok     <= 1'b0;
      end
      hbd_pkg::BLD_SCAN: begin
        // Scan runs upward, so an equal weight never displaces the lower index
        if (active[scan]) begin
          if (!lo_ok || wm < wlo) begin
            hi    <= lo;
            whi   <= wlo;
            hi_ok <= lo_ok;
            lo    <= scan;
            wlo   <= wm;
            lo_ok <= 1'b1;
          end else if (!hi_ok || wm < whi) begin
            hi    <= scan;
            whi   <= wm;
            hi_ok <= 1'b1;
          end
        end
        scan <= hbd_pkg::node_t'(scan + 1'b1);
      end
      hbd_pkg::BLD_MERGE: begin
        child[row][0]          <= lo;
        child[row][1]          <= hi;
        node_weight[next_node] <= hbd_pkg::sum_t'(wlo + whi);
        active[lo]             <= 1'b0;
        active[hi]             <= 1'b0;
        active[next_node]      <= 1'b1;
        next_node              <= hbd_pkg::node_t'(next_node + 1'b1);
        scan                   <= '0;
        lo_ok                  <= 1'b0;
        hi_ok                  <= 1'b0;
      end
      default: begin
      end
    endcase
  end

  assign tree.valid = tree_valid;
  assign tree.child = child;

endmodule

// ----- rtl/hbd_bit_decoder.sv -----
// Bit-by-bit tree walk with input register and result register.
`timescale 1ns / 1ps

module hbd_bit_decoder (
  input  logic                      clk,
  input  logic                      rst,
  input  hbd_pkg::tree_t            tree,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic                      code_bit,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic [hbd_pkg::SYM_W-1:0] symbol_index
);

  logic           in_full;
  logic           in_bit;
  hbd_pkg::node_t cur;

  logic                      advance;
  logic                      in_take;
  hbd_pkg::node_t            row_full;
  logic [hbd_pkg::INT_W-1:0] row;
  hbd_pkg::node_t            child;
  logic                      is_leaf;

  // Handshake: the input word moves on when the result slot is free or emptying
  assign advance  = in_full && (!out_valid || out_ready);
  assign in_ready = tree.valid && (!in_full || advance);
  assign in_take  = in_valid && in_ready;

  // Child lookup from the current internal node
  assign row_full = hbd_pkg::node_t'(cur - hbd_pkg::node_t'(hbd_pkg::SYMBOL_COUNT));
  assign row      = row_full[hbd_pkg::INT_W-1:0];
  assign child    = tree.child[row][in_bit];
  assign is_leaf  = (child < hbd_pkg::node_t'(hbd_pkg::SYMBOL_COUNT));

  // Control: input slot, walk position, result slot
  always_ff @(posedge clk) begin
    if (rst) begin
      in_full   <= 1'b0;
      out_valid <= 1'b0;
      cur       <= hbd_pkg::node_t'(hbd_pkg::ROOT_NODE);
    end else begin
      if (in_take) begin
        in_full <= 1'b1;
      end else if (advance) begin
        in_full <= 1'b0;
      end

      // Stale tree parks the walk at the root
      if (!tree.valid) begin
        cur <= hbd_pkg::node_t'(hbd_pkg::ROOT_NODE);
      end else if (advance) begin
        cur <= is_leaf ? hbd_pkg::node_t'(hbd_pkg::ROOT_NODE) : child;
      end

      if (advance && is_leaf) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Payload
  always_ff @(posedge clk) begin
    if (in_take) begin
      in_bit <= code_bit;
    end
    if (advance && is_leaf) begin
      symbol_index <= hbd_pkg::SYM_W'(child);
    end
  end

endmodule

// ----- rtl/huffman_tree_build_and_bit_decode_core.sv -----
// Top level of the eight-symbol Huffman tree builder and bit decoder.
`timescale 1ns / 1ps

// Usage
//   cfg channel: cfg_valid/cfg_ready with cfg_index and cfg_data write symbol
//   weight cfg_index (0..7); higher indices are dropped. cfg_ready is always
//   high. Write only while the decoder is idle. A write that changes a weight
//   starts a rebuild and puts the walk back at the root; rewriting the same
//   value leaves tree and walk untouched.
//   in channel: one code_bit per word. in_ready stays low while the tree is
//   being built after reset or a weight change. The build scans one node per
//   cycle for each of the seven merges, each scan followed by a merge step.
//   out channel: symbol_index word once a leaf is reached.
//   Throughput: one bit per cycle while the result is not stalled, set by
//   the single child lookup from the current node register. An accepted bit
//   waits in the input register; a leaf then loads the result register.
//   Stall: a held result keeps one further bit in the input register; after
//   that in_ready drops until out_ready returns.
//   Reset: synchronous, clears both channels, reloads the default weights and
//   rebuilds the tree.
module huffman_tree_build_and_bit_decode_core (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [hbd_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [hbd_pkg::WEIGHT_W-1:0]    cfg_data,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic                            code_bit,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [hbd_pkg::SYM_W-1:0]       symbol_index
);

  hbd_pkg::tree_t tree;

  // Tree builder with weight registers
  hbd_tree_builder u_builder (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .tree      (tree)
  );

  // Bit walker
  hbd_bit_decoder u_decoder (
    .clk          (clk),
    .rst          (rst),
    .tree         (tree),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .code_bit     (code_bit),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .symbol_index (symbol_index)
  );

endmodule

// ----- rtl/hbd_checker.sv -----
// Port-level checks for the Huffman decoder top level, bound to it.
`timescale 1ns / 1ps

module hbd_checker (
  input logic                      clk,
  input logic                      rst,
  input logic                      in_valid,
  input logic                      in_ready,
  input logic                      out_valid,
  input logic                      out_ready,
  input logic [hbd_pkg::SYM_W-1:0] symbol_index
);

  // A stalled result word holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(symbol_index))
    else $error("result word changed while stalled");

  // Tree is rebuilt after reset, so no bit is taken right away
  a_reset_build: assert property (@(posedge clk)
    rst |=> !in_ready)
    else $error("input ready straight after reset");

  // A new result only follows an earlier accepted input bit
  a_out_cause: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(in_valid && in_ready, 2))
    else $error("result word without a matching input word");

endmodule

bind huffman_tree_build_and_bit_decode_core hbd_checker u_hbd_checker (
  .clk          (clk),
  .rst          (rst),
  .in_valid     (in_valid),
  .in_ready     (in_ready),
  .out_valid    (out_valid),
  .out_ready    (out_ready),
  .symbol_index (symbol_index)
);
